>>> rtl/tsfe_pkg.sv
// tsfe_pkg: shared constants, types and a helper function for the tcp syn fingerprint extractor
// used by tsfe_datapath, tsfe_ctrl and the top level under rtl, no dependencies of its own
`timescale 1ns / 1ps

package tsfe_pkg;

  localparam int MAX_OPT_BYTES   = 40;
  localparam int MAX_EXT_HEADERS = 6;

  localparam int OPT_AW  = (MAX_OPT_BYTES > 1) ? $clog2(MAX_OPT_BYTES) : 1;
  localparam int OPT_CW  = $clog2(MAX_OPT_BYTES + 1);
  localparam int EXT_CW  = $clog2(MAX_EXT_HEADERS + 1) + 1;
  localparam int IP_BYTES  = 40;
  localparam int TCP_BYTES = 20;
  localparam int IP_AW   = $clog2(IP_BYTES);
  localparam int TCP_AW  = $clog2(TCP_BYTES);

  localparam logic [15:0] ETH_IPV4 = 16'h0800;
  localparam logic [15:0] ETH_IPV6 = 16'h86DD;

  localparam logic [7:0] PROTO_TCP    = 8'd6;
  localparam logic [7:0] NH_HOPOPT    = 8'd0;
  localparam logic [7:0] NH_ROUTING   = 8'd43;
  localparam logic [7:0] NH_FRAGMENT  = 8'd44;
  localparam logic [7:0] NH_ICMP6     = 8'd58;
  localparam logic [7:0] NH_DSTOPT    = 8'd60;
  localparam logic [7:0] NH_MOBILITY  = 8'd135;

  localparam logic [15:0] IPV6_HDR_LEN = 16'd40;
  localparam logic [15:0] BASE_HDR_LEN = 16'd20;

  typedef enum logic [1:0] {
    IPV_NONE,
    IPV_4,
    IPV_6
  } ipv_t;

  typedef enum logic [1:0] {
    KIND_REC = 2'd0,
    KIND_OPT = 2'd1,
    KIND_DEL = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    SEL_REC,
    SEL_OPT,
    SEL_DEL_SRC,
    SEL_DEL_DST
  } sel_t;

  typedef enum logic [2:0] {
    ST_PARSE,
    ST_JUDGE,
    ST_REC,
    ST_OPT_RD,
    ST_OPT_WR,
    ST_DEL_SRC,
    ST_DEL_DST
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    sel_t sel;
    logic opt_clr;
    logic opt_inc;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic syn_ok;
    logic del_ok;
    logic opts_zero;
    logic opt_last;
    logic out_free;
  } status_t;

  function automatic logic is_ext(input logic [7:0] p);
    is_ext = (p == NH_HOPOPT) || (p == NH_ROUTING) || (p == NH_FRAGMENT) ||
             (p == NH_ICMP6) || (p == NH_DSTOPT) || (p == NH_MOBILITY);
  endfunction

endpackage

>>> rtl/tsfe_ram.sv
// tsfe_ram: generic single write port ram with one registered read port
// no dependencies
`timescale 1ns / 1ps

module tsfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 40
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/tsfe_datapath.sv
// tsfe_datapath: header capture, extension walk, packet judging and the result register
// depends on tsfe_pkg and tsfe_ram
`timescale 1ns / 1ps

module tsfe_datapath (
  input  logic               clk,
  input  logic               rst,
  input  tsfe_pkg::cmd_t     cmd,
  output tsfe_pkg::status_t  stat,
  input  logic [7:0]         pkt_byte,
  input  logic               first_byte,
  input  logic               last_byte,
  input  logic [15:0]        ether_type,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic               last,
  output logic [63:0]        addr_hi,
  output logic [63:0]        addr_lo,
  output logic [15:0]        src_port,
  output logic [15:0]        dst_port,
  output logic [7:0]         opt_byte,
  output logic [7:0]         ttl,
  output logic [9:0]         flag_bits,
  output logic [15:0]        frag_word,
  output logic [15:0]        window_size,
  output logic [55:0]        size_word
);

  logic [15:0]                    off, off_next;
  logic                           run, run_next;
  tsfe_pkg::ipv_t                 ipv, ipv_new;
  logic [7:0]                     ipb [tsfe_pkg::IP_BYTES];
  logic [7:0]                     tcb [tsfe_pkg::TCP_BYTES];
  logic [7:0]                     nh, nh_next;
  logic [tsfe_pkg::EXT_CW-1:0]    ext_cnt, ext_cnt_next;
  logic                           ext_done, ext_done_next;
  logic [7:0]                     ext_pend, ext_pend_next;
  logic [15:0]                    ext_pos, ext_pos_next;
  logic [15:0]                    tcp_off, tcp_off_next;
  logic                           tcp_known, tcp_known_next;
  logic [16:0]                    len, len_next;
  logic [tsfe_pkg::OPT_CW-1:0]    k;

  logic                           start, absorb;
  tsfe_pkg::ipv_t                 c_ipv;
  logic [15:0]                    c_off, c_pos, c_toff, pos_sum;
  logic [7:0]                     c_nh, c_pend;
  logic [tsfe_pkg::EXT_CW-1:0]    c_cnt;
  logic                           c_done, c_tknown;
  logic                           tk;
  logic [15:0]                    to;
  logic [16:0]                    rel, opt_rel;
  logic                           ip_we, tcp_we, opt_we;
  logic [7:0]                     opt_rd;

  assign ipv_new = (ether_type == tsfe_pkg::ETH_IPV4) ? tsfe_pkg::IPV_4 :
                   (ether_type == tsfe_pkg::ETH_IPV6) ? tsfe_pkg::IPV_6 : tsfe_pkg::IPV_NONE;
  assign start  = cmd.accept && first_byte;
  assign absorb = cmd.accept && (start ? (ipv_new != tsfe_pkg::IPV_NONE) : run);

  always_comb begin
    c_off    = start ? 16'd0 : off;
    c_ipv    = start ? ipv_new : ipv;
    c_nh     = start ? 8'd0 : nh;
    c_cnt    = start ? '0 : ext_cnt;
    c_done   = start ? 1'b0 : ext_done;
    c_pend   = start ? 8'd0 : ext_pend;
    c_pos    = start ? tsfe_pkg::IPV6_HDR_LEN : ext_pos;
    c_toff   = start ? 16'd0 : tcp_off;
    c_tknown = start ? 1'b0 : tcp_known;

    off_next       = c_off;
    nh_next        = c_nh;
    ext_cnt_next   = c_cnt;
    ext_done_next  = c_done;
    ext_pend_next  = c_pend;
    ext_pos_next   = c_pos;
    tcp_off_next   = c_toff;
    tcp_known_next = c_tknown;
    run_next       = start ? (ipv_new != tsfe_pkg::IPV_NONE) : run;
    len_next       = len;
    pos_sum        = c_pos + {5'd0, pkt_byte, 3'b000} + 16'd8;

    if (absorb) begin
      if (c_ipv == tsfe_pkg::IPV_4 && c_off == 16'd0) begin
        tcp_off_next   = {10'd0, pkt_byte[3:0], 2'b00};
        tcp_known_next = 1'b1;
      end
      if (c_ipv == tsfe_pkg::IPV_6) begin
        if (c_off == 16'd6) begin
          nh_next = pkt_byte;
          if (tsfe_pkg::MAX_EXT_HEADERS == 0 || !tsfe_pkg::is_ext(pkt_byte)) begin
            ext_done_next  = 1'b1;
            tcp_off_next   = c_pos;
            tcp_known_next = 1'b1;
          end
        end else if (!c_done && c_off >= tsfe_pkg::IPV6_HDR_LEN && c_off == c_pos) begin
          ext_pend_next = pkt_byte;
        end else if (!c_done && c_off >= tsfe_pkg::IPV6_HDR_LEN &&
                     {1'b0, c_off} == {1'b0, c_pos} + 17'd1) begin
          nh_next      = c_pend;
          ext_pos_next = pos_sum;
          ext_cnt_next = c_cnt + 1'b1;
          if (ext_cnt_next >= tsfe_pkg::EXT_CW'(tsfe_pkg::MAX_EXT_HEADERS) ||
              !tsfe_pkg::is_ext(c_pend)) begin
            ext_done_next  = 1'b1;
            tcp_off_next   = pos_sum;
            tcp_known_next = 1'b1;
          end
        end
      end
      if (c_off != 16'hFFFF) begin
        off_next = c_off + 16'd1;
      end
      if (last_byte) begin
        run_next = 1'b0;
        len_next = {1'b0, c_off} + 17'd1;
      end
    end
  end

  // tcp header position as seen by the current byte
  assign tk      = c_tknown || (c_ipv == tsfe_pkg::IPV_4 && c_off == 16'd0);
  assign to      = (c_ipv == tsfe_pkg::IPV_4 && c_off == 16'd0) ?
                   {10'd0, pkt_byte[3:0], 2'b00} : c_toff;
  assign rel     = {1'b0, c_off} - {1'b0, to};
  assign opt_rel = rel - 17'(tsfe_pkg::TCP_BYTES);
  assign ip_we   = absorb && (c_off < 16'(tsfe_pkg::IP_BYTES));
  assign tcp_we  = absorb && tk && (c_off >= to) && (rel < 17'(tsfe_pkg::TCP_BYTES));
  assign opt_we  = absorb && tk && (c_off >= to) && (rel >= 17'(tsfe_pkg::TCP_BYTES)) &&
                   (opt_rel < 17'(tsfe_pkg::MAX_OPT_BYTES));

  always_ff @(posedge clk) begin
    if (rst) begin
      off       <= '0;
      run       <= 1'b0;
      ipv       <= tsfe_pkg::IPV_NONE;
      nh        <= '0;
      ext_cnt   <= '0;
      ext_done  <= 1'b0;
      ext_pend  <= '0;
      ext_pos   <= tsfe_pkg::IPV6_HDR_LEN;
      tcp_off   <= '0;
      tcp_known <= 1'b0;
      len       <= '0;
    end else begin
      off       <= off_next;
      run       <= run_next;
      ipv       <= c_ipv;
      nh        <= nh_next;
      ext_cnt   <= ext_cnt_next;
      ext_done  <= ext_done_next;
      ext_pend  <= ext_pend_next;
      ext_pos   <= ext_pos_next;
      tcp_off   <= tcp_off_next;
      tcp_known <= tcp_known_next;
      len       <= len_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ip_we) begin
      ipb[c_off[tsfe_pkg::IP_AW-1:0]] <= pkt_byte;
    end
    if (tcp_we) begin
      tcb[rel[tsfe_pkg::TCP_AW-1:0]] <= pkt_byte;
    end
  end

  tsfe_ram #(
    .WIDTH(8),
    .DEPTH(tsfe_pkg::MAX_OPT_BYTES)
  ) u_opt_ram (
    .clk     (clk),
    .wr_en   (opt_we),
    .wr_addr (opt_rel[tsfe_pkg::OPT_AW-1:0]),
    .wr_data (pkt_byte),
    .rd_addr (k[tsfe_pkg::OPT_AW-1:0]),
    .rd_data (opt_rd)
  );

  // packet judging
  logic [7:0]  flags, opts;
  logic [5:0]  doff4;
  logic [15:0] sp, dp, olen, pay, pclass, tot;
  logic [63:0] shi, slo, dhi, dlo;
  logic [17:0] need_len;
  logic        is4, is6, ip_ok, tcp_ok, base_ok, syn, ecn;
  logic [7:0]  q;

  assign is4    = (ipv == tsfe_pkg::IPV_4);
  assign is6    = (ipv == tsfe_pkg::IPV_6);
  assign flags  = tcb[13];
  assign doff4  = {tcb[12][7:4], 2'b00};
  assign opts   = 8'({2'b00, doff4} + 8'd236);
  assign sp     = {tcb[0], tcb[1]};
  assign dp     = {tcb[2], tcb[3]};
  assign shi    = is6 ? {ipb[8], ipb[9], ipb[10], ipb[11], ipb[12], ipb[13], ipb[14], ipb[15]}
                      : 64'd0;
  assign slo    = is6 ? {ipb[16], ipb[17], ipb[18], ipb[19], ipb[20], ipb[21], ipb[22], ipb[23]}
                      : {32'd0, ipb[12], ipb[13], ipb[14], ipb[15]};
  assign dhi    = is6 ? {ipb[24], ipb[25], ipb[26], ipb[27], ipb[28], ipb[29], ipb[30], ipb[31]}
                      : 64'd0;
  assign dlo    = is6 ? {ipb[32], ipb[33], ipb[34], ipb[35], ipb[36], ipb[37], ipb[38], ipb[39]}
                      : {32'd0, ipb[16], ipb[17], ipb[18], ipb[19]};

  assign ip_ok    = is4 ? (len >= 17'd20 && ipb[9] == tsfe_pkg::PROTO_TCP) :
                    is6 ? (len >= 17'd40 && ext_done && nh == tsfe_pkg::PROTO_TCP) : 1'b0;
  assign tcp_ok   = tcp_known && (len >= {1'b0, tcp_off} + 17'd20);
  assign need_len = {2'b00, tcp_off} + 18'd20 + {10'd0, opts};
  assign base_ok  = ip_ok && tcp_ok;
  assign syn      = flags[1] && !flags[4];

  always_comb begin
    q = '0;
    if ((tcb[4] | tcb[5] | tcb[6] | tcb[7]) == 8'd0) q[2] = 1'b1;
    if ((tcb[8] | tcb[9] | tcb[10] | tcb[11]) != 8'd0 && !flags[2]) q[3] = 1'b1;
    if ((tcb[18] | tcb[19]) != 8'd0 && !flags[5]) q[5] = 1'b1;
    q[6] = flags[5];
    q[7] = flags[3];
    ecn  = (flags[7:6] != 2'b00) || tcb[12][0];
    if (is4) begin
      if ((ipb[4] | ipb[5]) != 8'd0) q[0] = 1'b1;
      if (ipb[1][1:0] != 2'b00) ecn = 1'b1;
      olen = tcp_off - tsfe_pkg::BASE_HDR_LEN;
      pay  = {ipb[2], ipb[3]} - tcp_off;
    end else begin
      if (ipb[1][3:0] != 4'd0 || ipb[2] != 8'd0 || ipb[3] != 8'd0) q[1] = 1'b1;
      if (ipb[1][5:4] != 2'b00) ecn = 1'b1;
      olen = tcp_off - tsfe_pkg::IPV6_HDR_LEN;
      pay  = {ipb[4], ipb[5]} - olen;
    end
    pclass = pay - tsfe_pkg::BASE_HDR_LEN - {8'd0, opts};
    tot    = tcp_off + {10'd0, doff4};
  end

  assign stat.done      = absorb && last_byte;
  assign stat.syn_ok    = base_ok && syn && (opts <= 8'(tsfe_pkg::MAX_OPT_BYTES)) &&
                          (opts == 8'd0 || {1'b0, len} >= need_len);
  assign stat.del_ok    = base_ok && !syn && (flags[0] || flags[2]);
  assign stat.opts_zero = (opts == 8'd0);
  assign stat.opt_last  = (8'(k) + 8'd1 == opts);
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.opt_clr) begin
      k <= '0;
    end else if (cmd.opt_inc) begin
      k <= k + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      last        <= 1'b0;
      addr_hi     <= '0;
      addr_lo     <= '0;
      src_port    <= '0;
      dst_port    <= '0;
      opt_byte    <= '0;
      ttl         <= '0;
      flag_bits   <= '0;
      frag_word   <= '0;
      window_size <= '0;
      size_word   <= '0;
      unique case (cmd.sel)
        tsfe_pkg::SEL_REC: begin
          kind        <= tsfe_pkg::KIND_REC;
          last        <= (opts == 8'd0);
          addr_hi     <= shi;
          addr_lo     <= slo;
          src_port    <= sp;
          dst_port    <= dp;
          ttl         <= is4 ? ipb[8] : ipb[7];
          flag_bits   <= {is6, ecn, q};
          frag_word   <= is4 ? {ipb[6], ipb[7]} : 16'd0;
          window_size <= {tcb[14], tcb[15]};
          size_word   <= {pclass, opts, olen, tot};
        end
        tsfe_pkg::SEL_OPT: begin
          kind     <= tsfe_pkg::KIND_OPT;
          last     <= stat.opt_last;
          opt_byte <= opt_rd;
        end
        tsfe_pkg::SEL_DEL_SRC: begin
          kind     <= tsfe_pkg::KIND_DEL;
          addr_hi  <= shi;
          addr_lo  <= slo;
          src_port <= sp;
          dst_port <= dp;
        end
        tsfe_pkg::SEL_DEL_DST: begin
          kind     <= tsfe_pkg::KIND_DEL;
          last     <= 1'b1;
          addr_hi  <= dhi;
          addr_lo  <= dlo;
          src_port <= dp;
          dst_port <= sp;
        end
        default: begin
          kind <= tsfe_pkg::KIND_REC;
        end
      endcase
    end
  end

endmodule

>>> rtl/tsfe_ctrl.sv
// tsfe_ctrl: sequencer for byte intake, judging and result emission
// depends on tsfe_pkg
`timescale 1ns / 1ps

module tsfe_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsfe_pkg::status_t  stat,
  output tsfe_pkg::cmd_t     cmd
);

  tsfe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsfe_pkg::ST_PARSE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.accept  = 1'b0;
    cmd.load    = 1'b0;
    cmd.sel     = tsfe_pkg::SEL_REC;
    cmd.opt_clr = 1'b0;
    cmd.opt_inc = 1'b0;
    unique case (state)
      tsfe_pkg::ST_PARSE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (stat.done) begin
          state_next = tsfe_pkg::ST_JUDGE;
        end
      end
      tsfe_pkg::ST_JUDGE: begin
        if (stat.syn_ok) begin
          state_next = tsfe_pkg::ST_REC;
        end else if (stat.del_ok) begin
          state_next = tsfe_pkg::ST_DEL_SRC;
        end else begin
          state_next = tsfe_pkg::ST_PARSE;
        end
      end
      tsfe_pkg::ST_REC: begin
        cmd.opt_clr = 1'b1;
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = tsfe_pkg::SEL_REC;
          state_next = stat.opts_zero ? tsfe_pkg::ST_PARSE : tsfe_pkg::ST_OPT_RD;
        end
      end
      tsfe_pkg::ST_OPT_RD: begin
        state_next = tsfe_pkg::ST_OPT_WR;
      end
      tsfe_pkg::ST_OPT_WR: begin
        if (stat.out_free) begin
          cmd.load    = 1'b1;
          cmd.sel     = tsfe_pkg::SEL_OPT;
          cmd.opt_inc = 1'b1;
          state_next  = stat.opt_last ? tsfe_pkg::ST_PARSE : tsfe_pkg::ST_OPT_RD;
        end
      end
      tsfe_pkg::ST_DEL_SRC: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = tsfe_pkg::SEL_DEL_SRC;
          state_next = tsfe_pkg::ST_DEL_DST;
        end
      end
      tsfe_pkg::ST_DEL_DST: begin
        if (stat.out_free) begin
          cmd.load   = 1'b1;
          cmd.sel    = tsfe_pkg::SEL_DEL_DST;
          state_next = tsfe_pkg::ST_PARSE;
        end
      end
      default: begin
        state_next = tsfe_pkg::ST_PARSE;
      end
    endcase
  end

endmodule

>>> rtl/tcp_syn_fingerprint_extractor.sv
// tcp_syn_fingerprint_extractor: top level, joins the sequencer and the datapath
// depends on tsfe_pkg, tsfe_ctrl, tsfe_datapath and tsfe_ram
`timescale 1ns / 1ps

// Packet bytes are taken one per cycle from the start of the IP header while the
// sequencer is parsing. After the final byte of an IPv4 or IPv6 packet, input is held
// off for the judging state and then while results go out: a fingerprint record, then
// each TCP option byte in a read state and a load state (the option buffer is a memory
// with a registered read), or a source and then a destination delete key; each load
// waits while the output side stalls. A packet that gives no result holds input off
// only for the judging state.

module tcp_syn_fingerprint_extractor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  pkt_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  input  logic [15:0] ether_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic        last,
  output logic [63:0] addr_hi,
  output logic [63:0] addr_lo,
  output logic [15:0] src_port,
  output logic [15:0] dst_port,
  output logic [7:0]  opt_byte,
  output logic [7:0]  ttl,
  output logic [9:0]  flag_bits,
  output logic [15:0] frag_word,
  output logic [15:0] window_size,
  output logic [55:0] size_word
);

  tsfe_pkg::cmd_t    cmd;
  tsfe_pkg::status_t stat;

  tsfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tsfe_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .pkt_byte    (pkt_byte),
    .first_byte  (first_byte),
    .last_byte   (last_byte),
    .ether_type  (ether_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .last        (last),
    .addr_hi     (addr_hi),
    .addr_lo     (addr_lo),
    .src_port    (src_port),
    .dst_port    (dst_port),
    .opt_byte    (opt_byte),
    .ttl         (ttl),
    .flag_bits   (flag_bits),
    .frag_word   (frag_word),
    .window_size (window_size),
    .size_word   (size_word)
  );

`ifndef ASSERT_OFF
  a_kind_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == tsfe_pkg::KIND_REC || kind == tsfe_pkg::KIND_OPT ||
                   kind == tsfe_pkg::KIND_DEL))
    else $error("result kind out of range");

  a_judge_stall: assert property (@(posedge clk) disable iff (rst)
    stat.done |=> !in_ready)
    else $error("input taken during judging");

  a_non_rec_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != tsfe_pkg::KIND_REC) |-> (ttl == 8'd0 && size_word == 56'd0))
    else $error("record fields set on a non record result");
`endif

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking testbench for tcp_syn_fingerprint_extractor
// depends on tsfe_pkg and the rtl top level; drives packet bytes and checks every result
`timescale 1ns / 1ps

module tb_top;
  import tsfe_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int NUM_RAND_PKTS = 60;

  typedef struct {
    logic [1:0]  kind;
    logic        last;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [7:0]  ob;
    logic [7:0]  ttl;
    logic [9:0]  fl;
    logic [15:0] frag;
    logic [15:0] win;
    logic [55:0] sz;
  } fp_result_t;

  typedef struct {
    int         ver;
    int         ihl;
    int         doff;
    int         next;
    logic [7:0] flags;
    int         trunc;
    int         fill;
    bit         tcp_ok;
    int         special;
    bit         none;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  pkt_byte = 8'd0;
  logic        first_byte = 1'b0;
  logic        last_byte = 1'b0;
  logic [15:0] ether_type = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic        last;
  logic [63:0] addr_hi;
  logic [63:0] addr_lo;
  logic [15:0] src_port;
  logic [15:0] dst_port;
  logic [7:0]  opt_byte;
  logic [7:0]  ttl;
  logic [9:0]  flag_bits;
  logic [15:0] frag_word;
  logic [15:0] window_size;
  logic [55:0] size_word;

  tcp_syn_fingerprint_extractor DUT (.*);

  always #5 clk = ~clk;

  int  fails = 0;
  int  cyc = 0;
  int  n_pushed = 0;
  bit  idle_on = 1'b1;
  bit  long_hold = 1'b0;
  fp_result_t expected_results[$];

  // predictor state
  logic [15:0] p_off;
  bit          p_run;
  int          p_ver;
  logic [7:0]  ip_b[40];
  logic [7:0]  tcp_b[20];
  logic [7:0]  opt_b[40];
  logic [7:0]  p_nh;
  logic [7:0]  ext_pend;
  int          ext_cnt;
  bit          ext_done;
  int unsigned ext_pos;
  int unsigned tcp_off;
  bit          tcp_known;

  function automatic bit is_skipped_hdr(logic [7:0] p);
    return p == NH_HOPOPT || p == NH_ROUTING || p == NH_FRAGMENT ||
           p == NH_ICMP6 || p == NH_DSTOPT || p == NH_MOBILITY;
  endfunction

  function void start_parse(logic [15:0] et);
    for (int i = 0; i < 40; i++) ip_b[i] = 8'd0;
    for (int i = 0; i < 20; i++) tcp_b[i] = 8'd0;
    p_off = 16'd0;
    p_nh = 8'd0;
    ext_cnt = 0;
    ext_done = 1'b0;
    ext_pend = 8'd0;
    ext_pos = 40;
    tcp_off = 0;
    tcp_known = 1'b0;
    p_ver = (et == ETH_IPV4) ? 4 : (et == ETH_IPV6) ? 6 : 0;
    p_run = (p_ver != 0);
  endfunction

  function void ext_close();
    ext_done = 1'b1;
    tcp_off = ext_pos;
    tcp_known = 1'b1;
  endfunction

  function automatic logic [63:0] ip_be(int s, int n);
    logic [63:0] v;
    v = 64'd0;
    for (int k = 0; k < n; k++) v = {v[55:0], ip_b[s + k]};
    return v;
  endfunction

  function void push_result(fp_result_t r);
    expected_results.push_back(r);
    n_pushed++;
  endfunction

  function automatic fp_result_t blank_result();
    fp_result_t r;
    r.kind = KIND_REC; r.last = 0; r.hi = 0; r.lo = 0; r.sp = 0; r.dp = 0;
    r.ob = 0; r.ttl = 0; r.fl = 0; r.frag = 0; r.win = 0; r.sz = 0;
    return r;
  endfunction

  function void judge_packet(int unsigned len);
    logic [63:0] shi, slo, dhi, dlo;
    logic [15:0] sp, dp, olen, pay, pcl, tot, frag;
    logic [7:0]  fl, hop;
    logic [9:0]  q;
    bit          ecn;
    int unsigned doff4, opts;
    fp_result_t  r;
    shi = 0; dhi = 0; frag = 0;
    if (p_ver == 4) begin
      if (len < 20 || ip_b[9] != PROTO_TCP) return;
      slo = ip_be(12, 4);
      dlo = ip_be(16, 4);
    end else if (p_ver == 6) begin
      if (len < 40 || !ext_done || p_nh != PROTO_TCP) return;
      shi = ip_be(8, 8);
      slo = ip_be(16, 8);
      dhi = ip_be(24, 8);
      dlo = ip_be(32, 8);
    end else begin
      return;
    end
    if (!tcp_known || len < tcp_off + 20) return;
    fl = tcp_b[13];
    sp = {tcp_b[0], tcp_b[1]};
    dp = {tcp_b[2], tcp_b[3]};
    if (fl[1] && !fl[4]) begin
      doff4 = tcp_b[12][7:4] * 4;
      opts = (doff4 + 236) & 255;
      if (opts > MAX_OPT_BYTES || opts > 40) return;
      if (opts != 0 && len < tcp_off + 20 + opts) return;
      q = 10'd0;
      if ((tcp_b[4] | tcp_b[5] | tcp_b[6] | tcp_b[7]) == 0) q[2] = 1'b1;
      if ((tcp_b[8] | tcp_b[9] | tcp_b[10] | tcp_b[11]) != 0 && !fl[2]) q[3] = 1'b1;
      if ((tcp_b[18] | tcp_b[19]) != 0 && !fl[5]) q[5] = 1'b1;
      if (fl[5]) q[6] = 1'b1;
      if (fl[3]) q[7] = 1'b1;
      ecn = (fl[7:6] != 0) || tcp_b[12][0];
      if (p_ver == 4) begin
        if ((ip_b[4] | ip_b[5]) != 0) q[0] = 1'b1;
        if (ip_b[1][1:0] != 0) ecn = 1'b1;
        frag = {ip_b[6], ip_b[7]};
        hop = ip_b[8];
        olen = tcp_off - 20;
        pay = {ip_b[2], ip_b[3]} - tcp_off[15:0];
      end else begin
        if (ip_b[1][3:0] != 0 || ip_b[2] != 0 || ip_b[3] != 0) q[1] = 1'b1;
        if (ip_b[1][5:4] != 0) ecn = 1'b1;
        hop = ip_b[7];
        olen = tcp_off - 40;
        pay = {ip_b[4], ip_b[5]} - olen;
        q[9] = 1'b1;
      end
      q[8] = ecn;
      pcl = pay - 16'd20 - opts[15:0];
      tot = tcp_off[15:0] + doff4[15:0];
      r = blank_result();
      r.kind = KIND_REC;
      r.last = (opts == 0);
      r.hi = shi; r.lo = slo; r.sp = sp; r.dp = dp;
      r.ttl = hop; r.fl = q; r.frag = frag;
      r.win = {tcp_b[14], tcp_b[15]};
      r.sz = {pcl, opts[7:0], olen, tot};
      push_result(r);
      for (int k = 0; k < opts; k++) begin
        r = blank_result();
        r.kind = KIND_OPT;
        r.ob = opt_b[k];
        r.last = (k + 1 == opts);
        push_result(r);
      end
    end else if (fl[0] || fl[2]) begin
      r = blank_result();
      r.kind = KIND_DEL; r.hi = shi; r.lo = slo; r.sp = sp; r.dp = dp;
      push_result(r);
      r.hi = dhi; r.lo = dlo; r.sp = dp; r.dp = sp; r.last = 1'b1;
      push_result(r);
    end
  endfunction

  function void predict_byte(logic [7:0] b, logic f, logic l, logic [15:0] et);
    int unsigned off, k;
    if (f) start_parse(et);
    if (!p_run) return;
    off = p_off;
    if (off < 40) ip_b[off] = b;
    if (p_ver == 4 && off == 0) begin
      tcp_off = b[3:0] * 4;
      tcp_known = 1'b1;
    end
    if (p_ver == 6) begin
      if (off == 6) begin
        p_nh = b;
        if (MAX_EXT_HEADERS == 0 || !is_skipped_hdr(b)) ext_close();
      end else if (!ext_done && off >= 40 && off == ext_pos) begin
        ext_pend = b;
      end else if (!ext_done && off >= 40 && off == ext_pos + 1) begin
        p_nh = ext_pend;
        ext_pos = ext_pos + b * 8 + 8;
        ext_cnt++;
        if (ext_cnt >= MAX_EXT_HEADERS || !is_skipped_hdr(p_nh)) ext_close();
      end
    end
    if (tcp_known && off >= tcp_off && off < tcp_off + 20) tcp_b[off - tcp_off] = b;
    if (tcp_known && off >= tcp_off + 20) begin
      k = off - (tcp_off + 20);
      if (k < MAX_OPT_BYTES && k < 40) opt_b[k] = b;
    end
    if (p_off != 16'hFFFF) p_off++;
    if (!l) return;
    p_run = 1'b0;
    judge_packet(off + 1);
  endfunction

  initial begin
    for (int i = 0; i < 40; i++) opt_b[i] = 8'd0;
    start_parse(16'd0);
    p_run = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) predict_byte(pkt_byte, first_byte, last_byte, ether_type);
  end

  function void chk(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $error("%s expected %0h got %0h", nm, e, a);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    fp_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result kind %0d", kind);
        fails++;
      end else begin
        e = expected_results.pop_front();
        chk("kind", e.kind, kind);
        chk("last", e.last, last);
        chk("addr_hi", e.hi, addr_hi);
        chk("addr_lo", e.lo, addr_lo);
        chk("src_port", e.sp, src_port);
        chk("dst_port", e.dp, dst_port);
        chk("opt_byte", e.ob, opt_byte);
        chk("ttl", e.ttl, ttl);
        chk("flag_bits", e.fl, flag_bits);
        chk("frag_word", e.frag, frag_word);
        chk("window_size", e.win, window_size);
        chk("size_word", e.sz, size_word);
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // packet builder
  logic [7:0]  pk[$];
  logic [15:0] pk_et;
  int          fill_mode;

  function automatic logic [7:0] rb();
    case (fill_mode)
      1: return 8'h00;
      2: return 8'hFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_ext();
    case ($urandom_range(0, 5))
      0: return NH_HOPOPT;
      1: return NH_ROUTING;
      2: return NH_FRAGMENT;
      3: return NH_ICMP6;
      4: return NH_DSTOPT;
      default: return NH_MOBILITY;
    endcase
  endfunction

  task automatic build_packet(input int ver, ihl, doff, next, input logic [7:0] flags,
                              input int trunc, fill, input bit tcp_ok);
    int          toff, optn, pay, sz, elen, drop;
    logic [7:0]  t, fin_nh;
    logic [15:0] lenw;
    logic [7:0]  ext_q[$];
    pk.delete();
    fill_mode = fill;
    if (ver < 0) begin
      sz = $urandom_range(1, 60);
      repeat (sz) pk.push_back($urandom);
      pk_et = $urandom;
      return;
    end
    optn = (doff >= 5) ? doff * 4 - 20 : 0;
    pay = $urandom_range(0, 3);
    fin_nh = tcp_ok ? PROTO_TCP : 8'd17;
    if (ver == 6) begin
      for (int i = 0; i < next; i++) begin
        elen = $urandom_range(0, 2);
        ext_q.push_back((i == next - 1) ? fin_nh : pick_ext());
        ext_q.push_back(elen);
        repeat (elen * 8 + 6) ext_q.push_back(rb());
      end
      toff = 40 + ext_q.size();
    end else begin
      toff = ihl * 4;
    end
    sz = toff + 20 + optn + pay;
    if (sz < 20) sz = 20;
    repeat (sz) pk.push_back(rb());
    if (ver == 6) begin
      t = rb();
      pk[0] = {4'h6, t[3:0]};
      lenw = sz - 40;
      pk[4] = lenw[15:8];
      pk[5] = lenw[7:0];
      pk[6] = (next > 0) ? pick_ext() : fin_nh;
      foreach (ext_q[j]) pk[40 + j] = ext_q[j];
      if ($urandom_range(0, 2) == 0) begin
        pk[1][3:0] = 4'd0; pk[2] = 8'd0; pk[3] = 8'd0;
      end
      pk_et = ETH_IPV6;
    end else begin
      pk[0] = {4'h4, ihl[3:0]};
      lenw = sz;
      pk[2] = lenw[15:8];
      pk[3] = lenw[7:0];
      if ($urandom_range(0, 3) == 0) begin
        pk[4] = 8'd0; pk[5] = 8'd0;
      end
      pk[9] = fin_nh;
      if (ver == 4) begin
        pk_et = ETH_IPV4;
      end else begin
        pk_et = $urandom;
        if (pk_et == ETH_IPV4 || pk_et == ETH_IPV6) pk_et[0] = ~pk_et[0];
      end
    end
    t = rb();
    pk[toff + 12] = {doff[3:0], 3'b000, t[0]};
    pk[toff + 13] = flags;
    if ($urandom_range(0, 3) == 0) for (int i = 4; i < 8; i++) pk[toff + i] = 8'd0;
    if ($urandom_range(0, 1) == 0) for (int i = 8; i < 12; i++) pk[toff + i] = 8'd0;
    if ($urandom_range(0, 1) == 0) begin
      pk[toff + 18] = 8'd0; pk[toff + 19] = 8'd0;
    end
    drop = (trunc < 0) ? pay - trunc : trunc;
    if (drop > pk.size() - 1) drop = pk.size() - 1;
    repeat (drop) void'(pk.pop_back());
  endtask

  // request side
  task automatic send_item(logic [7:0] b, logic f, logic l, logic [15:0] et);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pkt_byte <= b;
    first_byte <= f;
    last_byte <= l;
    ether_type <= et;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  task automatic send_pkt(bit no_last);
    foreach (pk[i])
      send_item(pk[i], i == 0, !no_last && i == pk.size() - 1, (i == 0) ? pk_et : 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_special(int special);
    if (special == 1) begin
      repeat (3) send_item($urandom, 1'b0, 1'($urandom), $urandom);
    end else if (special == 2) begin
      build_packet(4, 5, 6, 0, 8'h02, 0, 0, 1'b1);
      send_pkt(1'b1);
    end
  endtask

  dir_row_t dir_tab[18] = '{
    '{4, 5, 5, 0, 8'h02, 0, 1, 1'b1, 0, 1'b0},
    '{4, 5, 15, 0, 8'hEF, 0, 2, 1'b1, 0, 1'b0},
    '{4, 5, 5, 0, 8'h04, 0, 0, 1'b1, 0, 1'b0},
    '{4, 5, 5, 0, 8'h01, 0, 2, 1'b1, 0, 1'b0},
    '{4, 5, 5, 0, 8'h12, 0, 0, 1'b1, 0, 1'b1},
    '{6, 0, 6, 0, 8'h02, 0, 0, 1'b1, 0, 1'b0},
    '{6, 0, 7, 3, 8'hC2, 0, 0, 1'b1, 0, 1'b0},
    '{6, 0, 5, 6, 8'h04, 0, 2, 1'b1, 0, 1'b0},
    '{6, 0, 5, 7, 8'h02, 0, 0, 1'b1, 0, 1'b1},
    '{0, 5, 5, 0, 8'h02, 0, 0, 1'b1, 0, 1'b1},
    '{4, 5, 5, 0, 8'h02, 0, 0, 1'b0, 0, 1'b1},
    '{4, 5, 5, 0, 8'h02, 30, 0, 1'b1, 0, 1'b1},
    '{4, 3, 5, 0, 8'h02, 0, 0, 1'b1, 0, 1'b0},
    '{4, 5, 3, 0, 8'h02, 0, 0, 1'b1, 0, 1'b1},
    '{4, 5, 8, 0, 8'h02, -2, 0, 1'b1, 0, 1'b1},
    '{4, 15, 5, 0, 8'h2A, 0, 0, 1'b1, 0, 1'b0},
    '{4, 5, 6, 0, 8'h05, 0, 0, 1'b1, 1, 1'b0},
    '{6, 0, 6, 2, 8'h02, 0, 0, 1'b1, 2, 1'b0}
  };

  initial begin : stimulus
    int         cnt0, sel, ver, ihl, doff, next, trunc;
    logic [7:0] fl;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      cnt0 = n_pushed;
      send_special(dir_tab[r].special);
      build_packet(dir_tab[r].ver, dir_tab[r].ihl, dir_tab[r].doff, dir_tab[r].next,
                   dir_tab[r].flags, dir_tab[r].trunc, dir_tab[r].fill, dir_tab[r].tcp_ok);
      send_pkt(1'b0);
      in_valid <= 1'b0;
      @(negedge clk);
      if (dir_tab[r].none && n_pushed != cnt0) begin
        $error("row %0d: expected no result", r);
        fails++;
      end
      @(posedge clk);
    end
    drain();

    for (int p = 0; p < NUM_RAND_PKTS; p++) begin
      idle_on = (p < NUM_RAND_PKTS * 4 / 5);
      if (p == 8) long_hold = 1'b1;
      if (p == 25) drain();
      case ($urandom_range(0, 3))
        0, 1: fl = ($urandom & 8'hEF) | 8'h02;
        2: fl = ($urandom & 8'hEA) | (($urandom_range(0, 1) != 0) ? 8'h01 : 8'h04);
        default: fl = $urandom;
      endcase
      sel = $urandom_range(0, 99);
      doff = (sel < 70) ? $urandom_range(5, 7) : (sel < 85) ? $urandom_range(8, 15) :
             $urandom_range(0, 15);
      ihl = ($urandom_range(0, 99) < 85) ? $urandom_range(5, 7) : $urandom_range(0, 15);
      next = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(4, 8);
      trunc = 0;
      sel = $urandom_range(0, 9);
      if (sel == 9) send_special($urandom_range(1, 2));
      if (sel <= 3 || sel == 9) ver = 4;
      else if (sel <= 6) ver = 6;
      else if (sel == 7) begin
        ver = ($urandom_range(0, 1) != 0) ? 4 : 6;
        trunc = $urandom_range(1, 50);
      end else ver = ($urandom_range(0, 1) != 0) ? -1 : 0;
      build_packet(ver, ihl, doff, next, fl, trunc, ($urandom_range(0, 19) == 0) ? 2 : 0,
                   $urandom_range(0, 9) != 0);
      send_pkt(1'b0);
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tsfe_pkg.sv
rtl/tsfe_ram.sv
rtl/tsfe_datapath.sv
rtl/tsfe_ctrl.sv
rtl/tcp_syn_fingerprint_extractor.sv
dv/tb_top.sv
